>>> sv/tfdi_pkg.sv
package tfdi_pkg;

  localparam int ACC_W = 48;
  localparam int SEC_W = 32;
  localparam int MPG_W = 17;
  localparam int AVG_W = 15;
  localparam int RED_W = 14;
  localparam logic [RED_W-1:0] REDLINE_RST = 14'd6000;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
  localparam logic [SEC_W-1:0] SEC_MAX = {SEC_W{1'b1}};
  localparam logic [MPG_W-1:0] COAST_MPG = 17'd6000;
  localparam logic [MPG_W-1:0] MPG_MAX = {MPG_W{1'b1}};
  localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};
  localparam logic [9:0] IDLE_RATE = 10'd200;
  localparam logic [6:0] LOAD_PCT = 7'd80;
  localparam logic [6:0] THR_MAX = 7'd100;
  localparam logic [3:0] PERSIST_PERIOD = 4'd15;
  localparam logic [16:0] MPG_SCALE = 17'd100000;
  localparam logic [11:0] HOUR_SCALE = 12'd3600;
  localparam logic REG_RUN = 1'b0;
  localparam logic REG_REDLINE = 1'b1;
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam int DIV_W = 64;
  localparam int DIV_CW = $clog2(DIV_W + 1);

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

endpackage

>>> sv/tfdi_div.sv
module tfdi_div
  import tfdi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]  den_r;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [DIV_W:0]    shl;
  logic [DIV_W:0]    dif;

  // restoring divider, one quotient bit per cycle
  always_comb begin
    shl = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
    dif = shl - {1'b0, den_r};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt = req.num;
      rem_nxt = '0;
      cnt_nxt = DIV_CW'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!dif[DIV_W]) begin
        rem_nxt = dif;
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shl;
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) den_r <= req.den;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo = quo_r;

`ifndef SYNTHESIS
  a_cnt_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("divider busy with zero count");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without work");
  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(done_r && busy_r)) else $error("divider done while busy");
`endif

endmodule

>>> sv/tfdi_mul.sv
module tfdi_mul
  import tfdi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] a,
  input  logic [31:0]      b,
  output logic             done,
  output logic [DIV_W-1:0] prod
);

  // shift-add multiplier, one bit of b per cycle
  logic [DIV_W-1:0] acc_r, a_r;
  logic [31:0]      b_r;
  logic [5:0]       cnt_r;
  logic             busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      acc_r <= '0;
      a_r <= a;
      b_r <= b;
    end else if (busy_r) begin
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r <= {a_r[DIV_W-2:0], 1'b0};
      b_r <= {1'b0, b_r[31:1]};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

`ifndef SYNTHESIS
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("multiplier busy with zero count");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("multiplier done without work");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(done_r && busy_r)) else $error("multiplier done while busy");
`endif

endmodule

>>> sv/trip_fuel_distance_integrator.sv
// Channel | Dir | tdata (low bit up)                       | tuser
// in_     | in  | elapsed_ms, speed_mph, engine_rpm,        | req_type
//         |     | throttle_pct                              |
// out_    | out | distance, fuel, avg_speed, instant_mpg,    | persist_due
//         |     | trip_seconds                              |
// cfg_    | in  | index 0 run_enable, 1 redline_rpm          |
// One item at a time. An enabled tick with speed and elapsed both nonzero has
// its result beat valid after three passes of the shift-add multiplier and five
// passes of the divider; without both nonzero the mpg division is skipped. A
// clear or disabled tick only divides for distance, fuel and, unless trip
// seconds is zero, average. in_tready is low from acceptance until the result
// beat is taken; out_tvalid holds the beat. Reset is synchronous, active low.
module trip_fuel_distance_integrator
  import tfdi_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // elapsed_ms[15:0], speed_mph[23:16],
                                   // engine_rpm[37:24], throttle_pct[45:38]
  input  logic         in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // distance[31:0], fuel[63:32],
                                   // avg[78:64], mpg[95:79], seconds[127:96]
  output logic         out_tuser,  // persist_due
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [13:0]  cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_RMUL, S_RDIV, S_MPG, S_FMUL, S_DMUL, S_DIST, S_FUEL, S_AVG, S_OUT
  } state_t;

  state_t             state_r;
  logic               run_r;
  logic [RED_W-1:0]   red_r;
  logic [ACC_W-1:0]   dist_r, fuel_r;
  logic [SEC_W-1:0]   sec_r;
  logic [MPG_W-1:0]   mpg_r;
  logic               pers_r;
  logic [3:0]         pcnt_r;
  logic [15:0]        el_r;
  logic [7:0]         spd_r;
  logic [RED_W-1:0]   rpmc_r;
  logic               rpmnz_r;
  logic [6:0]         thr_r;
  logic [RED_W-1:0]   redu_r;
  logic [15:0]        rate_r;
  logic               go_r;
  logic [31:0]        odist_r, ofuel_r;
  logic [AVG_W-1:0]   oavg_r;

  div_req_t           dreq;
  div_rsp_t           drsp;
  logic               mstart;
  logic [DIV_W-1:0]   ma;
  logic [31:0]        mb;
  logic               mdone;
  logic [DIV_W-1:0]   mprod;

  logic [7:0]         thr_in;
  logic [RED_W-1:0]   rpm_in;
  logic [RED_W-1:0]   red_eff;
  logic [ACC_W:0]     sum;

  tfdi_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
  tfdi_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb),
                  .done(mdone), .prod(mprod));

  assign thr_in = in_tdata[45:38];
  assign rpm_in = in_tdata[37:24];
  assign red_eff = (red_r == '0) ? RED_W'(1) : red_r;
  assign in_tready = (state_r == S_IDLE);
  assign sum = {1'b0, (state_r == S_FMUL) ? fuel_r : dist_r} +
               {1'b0, mprod[ACC_W-1:0]};

  always_comb begin
    dreq = '0;
    mstart = 1'b0;
    ma = '0;
    mb = '0;
    if (go_r) begin
      case (state_r)
        S_RMUL: begin
          mstart = 1'b1;
          ma = DIV_W'(14'(LOAD_PCT) * 14'(thr_r));
          mb = 32'(rpmc_r);
        end
        S_RDIV: begin
          dreq.start = 1'b1;
          dreq.num = mprod;
          dreq.den = DIV_W'(redu_r);
        end
        S_MPG: begin
          dreq.start = 1'b1;
          dreq.num = DIV_W'(25'(spd_r) * 25'(MPG_SCALE));
          dreq.den = DIV_W'(rate_r);
        end
        S_FMUL: begin
          mstart = 1'b1;
          ma = DIV_W'(rate_r);
          mb = 32'(el_r);
        end
        S_DMUL: begin
          mstart = 1'b1;
          ma = DIV_W'(spd_r);
          mb = 32'(el_r);
        end
        S_DIST, S_FUEL: begin
          dreq.start = 1'b1;
          dreq.num = DIV_W'((state_r == S_DIST) ? dist_r : fuel_r);
          dreq.den = DIV_W'(HOUR_SCALE);
        end
        S_AVG: begin
          dreq.start = 1'b1;
          dreq.num = DIV_W'(dist_r);
          dreq.den = DIV_W'({sec_r, 3'b000}) + DIV_W'({sec_r, 1'b0});
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      run_r <= 1'b0;
      red_r <= REDLINE_RST;
      dist_r <= '0;
      fuel_r <= '0;
      sec_r <= '0;
      mpg_r <= '0;
      pers_r <= 1'b0;
      pcnt_r <= '0;
      go_r <= 1'b0;
    end else begin
      go_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_RUN) run_r <= cfg_wdata[0];
        else if (cfg_index == REG_REDLINE) red_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            el_r <= in_tdata[15:0];
            spd_r <= in_tdata[23:16];
            redu_r <= red_eff;
            rpmc_r <= (rpm_in > red_eff) ? red_eff : rpm_in;
            rpmnz_r <= (rpm_in != '0);
            thr_r <= (thr_in > 8'(THR_MAX)) ? THR_MAX : thr_in[6:0];
            pers_r <= 1'b0;
            go_r <= 1'b1;
            if (in_tuser == REQ_CLEAR) begin
              dist_r <= '0;
              fuel_r <= '0;
              sec_r <= '0;
              mpg_r <= '0;
              pcnt_r <= '0;
              state_r <= S_DIST;
            end else if (run_r) begin
              state_r <= S_RMUL;
            end else begin
              state_r <= S_DIST;
            end
          end
        end
        S_RMUL: begin
          if (mdone) begin
            go_r <= 1'b1;
            state_r <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (drsp.done) begin
            rate_r <= 16'(IDLE_RATE) + drsp.quo[15:0];
            go_r <= 1'b1;
            if (el_r != '0 && spd_r != '0) begin
              state_r <= S_MPG;
            end else begin
              mpg_r <= (spd_r != '0 && rpmnz_r) ? COAST_MPG : '0;
              state_r <= S_FMUL;
            end
          end
        end
        S_MPG: begin
          if (drsp.done) begin
            mpg_r <= (|drsp.quo[DIV_W-1:MPG_W]) ? MPG_MAX : drsp.quo[MPG_W-1:0];
            go_r <= 1'b1;
            state_r <= S_FMUL;
          end
        end
        S_FMUL: begin
          if (mdone) begin
            fuel_r <= sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
            go_r <= 1'b1;
            state_r <= S_DMUL;
          end
        end
        S_DMUL: begin
          if (mdone) begin
            dist_r <= sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
            // saturated count is itself a multiple of fifteen
            if (sec_r != SEC_MAX) begin
              sec_r <= sec_r + SEC_W'(1);
              pcnt_r <= (pcnt_r == PERSIST_PERIOD - 4'd1) ? '0 : pcnt_r + 4'd1;
              pers_r <= (pcnt_r == PERSIST_PERIOD - 4'd1);
            end else begin
              pers_r <= 1'b1;
            end
            go_r <= 1'b1;
            state_r <= S_DIST;
          end
        end
        S_DIST: begin
          if (drsp.done) begin
            odist_r <= (|drsp.quo[DIV_W-1:32]) ? '1 : drsp.quo[31:0];
            go_r <= 1'b1;
            state_r <= S_FUEL;
          end
        end
        S_FUEL: begin
          if (drsp.done) begin
            ofuel_r <= (|drsp.quo[DIV_W-1:32]) ? '1 : drsp.quo[31:0];
            if (sec_r == '0) begin
              oavg_r <= '0;
              state_r <= S_OUT;
            end else begin
              go_r <= 1'b1;
              state_r <= S_AVG;
            end
          end
        end
        S_AVG: begin
          if (drsp.done) begin
            oavg_r <= (|drsp.quo[DIV_W-1:AVG_W]) ? AVG_MAX : drsp.quo[AVG_W-1:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_tready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {sec_r, mpg_r, oavg_r, ofuel_r, odist_r};
  assign out_tuser = pers_r;

`ifndef SYNTHESIS
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input open while result waits");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");
  a_div_idle_at_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !drsp.busy) else $error("divider busy with result out");
  a_pcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r < PERSIST_PERIOD) else $error("persist counter out of range");
`endif

endmodule

>>> dv/trip_fuel_distance_integrator_tb.sv
`timescale 1ns / 100ps

module trip_fuel_distance_integrator_tb
  import tfdi_pkg::*;
();

  typedef struct packed {
    logic        req;
    logic [15:0] elapsed;
    logic [7:0]  speed;
    logic [13:0] rpm;
    logic [7:0]  throttle;
  } tick_t;

  typedef struct packed {
    logic [31:0] distance;
    logic [31:0] fuel;
    logic [14:0] avg;
    logic [16:0] mpg;
    logic [31:0] seconds;
    logic        persist;
  } totals_t;

  class trip_scoreboard;
    bit          run_en;
    logic [13:0] redline;
    logic [47:0] dist_acc;
    logic [47:0] fuel_acc;
    logic [31:0] secs;
    logic [16:0] mpg_held;
    totals_t     pending[$];
    int          errors;

    function void reset_state();
      run_en = 0;
      redline = REDLINE_RST;
      dist_acc = '0;
      fuel_acc = '0;
      secs = '0;
      mpg_held = '0;
    endfunction

    function void write_reg(logic idx, logic [13:0] val);
      if (idx == REG_RUN) run_en = val[0];
      else if (idx == REG_REDLINE) redline = val;
    endfunction

    function void note_tick(tick_t t);
      longint unsigned red, tc, rc, rate, s, q;
      totals_t e;
      e.persist = 0;
      if (t.req == REQ_CLEAR) begin
        dist_acc = '0;
        fuel_acc = '0;
        secs = '0;
        mpg_held = '0;
      end else if (run_en) begin
        red = (redline == 0) ? 1 : redline;
        tc = (t.throttle > 100) ? 100 : t.throttle;
        rc = (t.rpm > red) ? red : t.rpm;
        rate = 200 + (80 * tc * rc) / red;
        s = longint'(dist_acc) + longint'(t.speed) * t.elapsed;
        dist_acc = (s > ACC_MAX) ? ACC_MAX : s[47:0];
        s = longint'(fuel_acc) + rate * t.elapsed;
        fuel_acc = (s > ACC_MAX) ? ACC_MAX : s[47:0];
        if (secs != SEC_MAX) secs = secs + 1;
        if (t.elapsed > 0 && t.speed > 0) begin
          q = (longint'(t.speed) * 100000) / rate;
          mpg_held = (q > MPG_MAX) ? MPG_MAX : q[16:0];
        end else if (t.speed > 0 && t.rpm > 0) mpg_held = COAST_MPG;
        else mpg_held = '0;
        e.persist = (secs % 15 == 0);
      end
      if (secs == 0) e.avg = '0;
      else begin
        q = longint'(dist_acc) / (10 * longint'(secs));
        e.avg = (q > AVG_MAX) ? AVG_MAX : q[14:0];
      end
      q = dist_acc / 3600;
      e.distance = (q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
      q = fuel_acc / 3600;
      e.fuel = (q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
      e.mpg = mpg_held;
      e.seconds = secs;
      pending.push_back(e);
    endfunction

    function void check_result(logic [127:0] d, logic u);
      totals_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat %h/%b", $time, d, u);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.distance) begin
        $display("%0t: distance exp %0d got %0d", $time, e.distance, d[31:0]); errors++;
      end
      if (d[63:32] !== e.fuel) begin
        $display("%0t: fuel exp %0d got %0d", $time, e.fuel, d[63:32]); errors++;
      end
      if (d[78:64] !== e.avg) begin
        $display("%0t: avg exp %0d got %0d", $time, e.avg, d[78:64]); errors++;
      end
      if (d[95:79] !== e.mpg) begin
        $display("%0t: mpg exp %0d got %0d", $time, e.mpg, d[95:79]); errors++;
      end
      if (d[127:96] !== e.seconds) begin
        $display("%0t: seconds exp %0d got %0d", $time, e.seconds, d[127:96]); errors++;
      end
      if (u !== e.persist) begin
        $display("%0t: persist exp %b got %b", $time, e.persist, u); errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [47:0]  in_tdata;   // elapsed, speed, rpm, throttle
  logic         in_tuser;   // req_type
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // distance, fuel, avg, mpg, seconds
  logic         out_tuser;  // persist_due
  logic         cfg_we;
  logic         cfg_index;
  logic [13:0]  cfg_wdata;

  trip_scoreboard sb;
  bit             stim_done;

  trip_fuel_distance_integrator u_dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("trip_fuel_distance_integrator_tb failed");
    $finish;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 600);
  endfunction

  task automatic write_reg(logic idx, logic [13:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_tick(tick_t t);
    int g;
    g = rand_gap();
    @(negedge clk);
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= t.req;
    in_tdata <= {2'b0, t.throttle, t.rpm, t.speed, t.elapsed};
    do @(posedge clk); while (!in_tready);
    sb.note_tick(t);
  endtask

  task automatic stop_in();
    @(negedge clk);
    in_tvalid <= 0;
  endtask

  function automatic tick_t rand_tick();
    tick_t t;
    int r;
    t.req = ($urandom_range(0, 49) == 0) ? REQ_CLEAR : REQ_TICK;
    r = $urandom_range(0, 9);
    t.elapsed = (r < 6) ? 16'($urandom_range(900, 1100)) :
                (r < 7) ? 16'd0 : 16'($urandom);
    t.speed = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
    t.rpm = ($urandom_range(0, 9) == 0) ? 14'd0 : 14'($urandom);
    t.throttle = 8'($urandom);
    return t;
  endfunction

  task automatic settle();
    stop_in();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (500) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) out_tready <= 0;
    else if (stim_done || $urandom_range(0, 9) < 6) out_tready <= 1;
    else out_tready <= 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  initial begin
    logic [13:0] reds[4];
    int w;
    sb = new();
    sb.reset_state();
    stim_done = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // a disabled tick first, then directed corners
    send_tick('{REQ_TICK, 16'd1000, 8'd60, 14'd3000, 8'd50});
    settle();
    write_reg(REG_RUN, 14'd1);
    send_tick('{REQ_TICK, 16'd1000, 8'd60, 14'd3000, 8'd50});
    send_tick('{REQ_TICK, 16'd0, 8'd60, 14'd3000, 8'd50});
    send_tick('{REQ_TICK, 16'd0, 8'd60, 14'd0, 8'd50});
    send_tick('{REQ_TICK, 16'd1000, 8'd0, 14'd3000, 8'd0});
    send_tick('{REQ_TICK, 16'hFFFF, 8'hFF, 14'h3FFF, 8'hFF});
    send_tick('{REQ_TICK, 16'd1, 8'd1, 14'd16383, 8'd101});
    send_tick('{REQ_TICK, 16'd1000, 8'd255, 14'd0, 8'd0});
    send_tick('{REQ_CLEAR, 16'hFFFF, 8'hFF, 14'h3FFF, 8'hFF});
    for (int i = 0; i < 16; i++)
      send_tick('{REQ_TICK, 16'd1000, 8'd30, 14'd2000, 8'd100});
    settle();
    write_reg(REG_RUN, 14'd0);
    send_tick('{REQ_TICK, 16'd1000, 8'd30, 14'd2000, 8'd100});
    settle();
    write_reg(REG_RUN, 14'd1);

    reds = '{14'd1000, 14'd16000, 14'd6000, 14'd0};
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      write_reg(REG_REDLINE, ph < 4 ? reds[ph] : 14'($urandom_range(1000, 16000)));
      if (ph == 5) write_reg(REG_RUN, 14'd0);
      if (ph == 5) begin
        for (int i = 0; i < 20; i++) send_tick(rand_tick());
        settle();
        write_reg(REG_RUN, 14'd1);
      end
      for (int i = 0; i < 300; i++) send_tick(rand_tick());
    end

    stop_in();
    stim_done = 1;
    w = 0;
    while (sb.pending.size() != 0 && w < 200000) begin
      @(negedge clk);
      w++;
    end
    repeat (500) @(negedge clk);
    if (sb.pending.size() == 0 && sb.errors == 0) begin
      $display("trip_fuel_distance_integrator_tb passed");
    end else begin
      $display("trip_fuel_distance_integrator_tb failed");
    end
    $finish;
  end

endmodule
